// File: design/fraction_reduce_sum_min_unit_defines.svh
// assertion macros shared by the fraction reduce / sum / min unit
// no dependencies; taken in by files that carry concurrent checks
`ifndef FRACTION_REDUCE_SUM_MIN_UNIT_DEFINES_SVH
`define FRACTION_REDUCE_SUM_MIN_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define FRSM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define FRSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/frsm_pkg.sv
// types and constants of the fraction reduce / sum / min unit
// no dependencies
`timescale 1ns / 1ps

package frsm_pkg;

    localparam int IN_W    = 16;           // input field width
    localparam int NUM_W   = IN_W + 1;     // sign-corrected numerator
    localparam int ACC_W   = 32;           // running sum numerator
    localparam int DEN_W   = ACC_W - 1;    // running sum denominator
    localparam int M_W     = ACC_W + NUM_W; // cross products and their sum
    localparam int CNT_W   = 6;            // divider step count
    localparam int K_W     = 5;            // gcd common power of two
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_ZERO_DEN = 2'd1,
        STAT_OVERFLOW = 2'd2
    } t_status;

    typedef enum logic {
        KIND_ITEM  = 1'b0,
        KIND_TOTAL = 1'b1
    } t_kind;

    // classified word: sign/magnitude numerator, positive denominator
    typedef struct packed {
        logic             zero;
        logic             last;
        logic             neg;
        logic [NUM_W-1:0] mag;
        logic [IN_W-1:0]  den;
    } t_item;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_GCD_ITEM,
        ST_DIV_N,
        ST_DIV_D,
        ST_MUL_MA,
        ST_MUL_MB,
        ST_MIN,
        ST_GCD_DEN,
        ST_DIV_A,
        ST_DIV_B,
        ST_MUL_1,
        ST_MUL_2,
        ST_ADD,
        ST_DIV_M,
        ST_GCD_REM,
        ST_DIV_Q,
        ST_DIV_DQ,
        ST_MUL_DEN,
        ST_CHECK,
        ST_OUT_ITEM,
        ST_OUT_SUM
    } t_state;

endpackage

// File: design/frsm_in_if.sv
// input channel of the fraction unit: valid/ready plus one fraction word
// depends on frsm_pkg
`timescale 1ns / 1ps

interface frsm_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [frsm_pkg::IN_W-1:0]   numerator;
    logic signed [frsm_pkg::IN_W-1:0]   denominator;
    logic                               last;

    modport source (output valid, numerator, denominator, last, input ready);
    modport sink   (input valid, numerator, denominator, last, output ready);
endinterface

// File: design/frsm_out_if.sv
// result channel of the fraction unit: valid/ready plus one result word
// depends on frsm_pkg
`timescale 1ns / 1ps

interface frsm_out_if;
    logic                                valid;
    logic                                ready;
    logic                                kind;
    logic signed [frsm_pkg::ACC_W-1:0]   num;
    logic [frsm_pkg::DEN_W-1:0]          den;
    logic signed [frsm_pkg::NUM_W-1:0]   min_num;
    logic [frsm_pkg::IN_W-1:0]           min_den;
    logic [1:0]                          status;
    logic                                end_of_run;

    modport source (output valid, kind, num, den, min_num, min_den, status, end_of_run,
                    input ready);
    modport sink   (input valid, kind, num, den, min_num, min_den, status, end_of_run,
                    output ready);
endinterface

// File: design/frsm_front.sv
// front end: takes input words, moves the sign to the numerator, flags zero denominators
// depends on frsm_pkg, frsm_in_if
`timescale 1ns / 1ps

module frsm_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    frsm_in_if.sink         i_item,
    input  logic            i_full,
    output logic            o_push,
    output frsm_pkg::t_item o_entry
);

    logic            r_vld;
    frsm_pkg::t_item r_entry;
    frsm_pkg::t_item n_entry;
    logic            accept;

    logic signed [frsm_pkg::NUM_W-1:0] num_ext;
    logic signed [frsm_pkg::NUM_W-1:0] num_fix;

    assign i_item.ready = !r_vld || !i_full;
    assign accept       = i_item.valid && i_item.ready;
    assign o_push       = r_vld && !i_full;
    assign o_entry      = r_entry;

    always_comb begin
        num_ext = frsm_pkg::NUM_W'(i_item.numerator);
        num_fix = i_item.denominator[frsm_pkg::IN_W-1] ? -num_ext : num_ext;
        n_entry.last = i_item.last;
        if (i_item.denominator == '0) begin
            n_entry.zero = 1'b1;
            n_entry.neg  = 1'b0;
            n_entry.mag  = '0;
            n_entry.den  = frsm_pkg::IN_W'(1);
        end else begin
            n_entry.zero = 1'b0;
            n_entry.neg  = num_fix[frsm_pkg::NUM_W-1];
            n_entry.mag  = num_fix[frsm_pkg::NUM_W-1] ? -num_fix : num_fix;
            // the most negative denominator negates to its own bit pattern, read unsigned
            n_entry.den  = i_item.denominator[frsm_pkg::IN_W-1] ? -i_item.denominator
                                                               : i_item.denominator;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (accept) begin
            r_vld <= 1'b1;
        end else if (o_push) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_entry <= n_entry;
        end
    end

endmodule

// File: design/frsm_queue.sv
// short queue of classified words between front end and sequencer
// depends on frsm_pkg
`timescale 1ns / 1ps

module frsm_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  frsm_pkg::t_item i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output frsm_pkg::t_item o_head
);

    frsm_pkg::t_item              r_mem [frsm_pkg::Q_DEPTH];
    logic [frsm_pkg::Q_AW-1:0]    r_wp;
    logic [frsm_pkg::Q_AW-1:0]    r_rp;
    logic [frsm_pkg::Q_AW:0]      r_cnt;
    logic                         push_ok;
    logic                         pop_ok;

    assign o_full  = r_cnt == (frsm_pkg::Q_AW+1)'(frsm_pkg::Q_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_head  = r_mem[r_rp];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wp <= r_wp + frsm_pkg::Q_AW'(1);
            end
            if (pop_ok) begin
                r_rp <= r_rp + frsm_pkg::Q_AW'(1);
            end
            if (push_ok && !pop_ok) begin
                r_cnt <= r_cnt + (frsm_pkg::Q_AW+1)'(1);
            end else if (pop_ok && !push_ok) begin
                r_cnt <= r_cnt - (frsm_pkg::Q_AW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= i_entry;
        end
    end

endmodule

// File: design/frsm_back.sv
// sequencer: gcd reduction, running minimum, exact reduced running sum, result register
// depends on frsm_pkg, frsm_out_if and the assertion macro header
`timescale 1ns / 1ps
`include "fraction_reduce_sum_min_unit_defines.svh"

module frsm_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  frsm_pkg::t_item i_entry,
    output logic            o_pop,
    frsm_out_if.source      o_res
);

    localparam int NW = frsm_pkg::NUM_W;
    localparam int IW = frsm_pkg::IN_W;
    localparam int AW = frsm_pkg::ACC_W;
    localparam int DW = frsm_pkg::DEN_W;
    localparam int MW = frsm_pkg::M_W;
    localparam int CW = frsm_pkg::CNT_W;
    localparam int KW = frsm_pkg::K_W;
    localparam logic [MW-1:0] DEN_MAX = MW'((64'd1 << DW) - 64'd1);
    localparam logic [MW-1:0] POS_MAX = MW'((64'd1 << (AW-1)) - 64'd1);
    localparam logic [MW-1:0] NEG_MAG = MW'(64'd1 << (AW-1));

    frsm_pkg::t_state r_state, n_state;
    logic             r_sub, n_sub;

    // item
    logic                r_last;
    logic                r_nneg;
    logic [NW-1:0]       r_nmag;
    logic [IW-1:0]       r_d;
    frsm_pkg::t_status   r_status;

    // sum work
    logic [AW-1:0]       r_g;
    logic [DW-1:0]       r_a;
    logic [IW-1:0]       r_b;
    logic [MW-1:0]       r_m1, r_m2, r_m, r_q, r_prod;
    logic                r_neg;
    logic [AW-1:0]       r_rem;
    logic [IW-1:0]       r_dq;
    logic signed [2*NW+1:0] r_pa, r_pb;

    // list state
    logic signed [AW-1:0] r_sn;
    logic [DW-1:0]        r_sd;
    logic signed [NW-1:0] r_mn;
    logic [NW-1:0]        r_md;
    logic                 r_mv;
    logic                 r_ov;

    // divider
    logic [MW-1:0]  r_dv_q;
    logic [AW-1:0]  r_dv_r;
    logic [AW-1:0]  r_dv_v;
    logic [CW-1:0]  r_dv_cnt;
    logic           dv_start;
    logic [MW-1:0]  dv_dividend;
    logic [CW-1:0]  dv_count;
    logic [AW:0]    dv_shift_r;
    logic           dv_ge;

    // binary gcd
    logic [AW-1:0]  r_gx, r_gy, r_gres;
    logic [KW-1:0]  r_gk;
    logic           r_gbusy;
    logic           gc_start;
    logic [AW-1:0]  gc_x, gc_y;

    // multipliers
    logic [AW-1:0]          bm_x;
    logic [NW-1:0]          bm_y;
    logic [MW-1:0]          bm_p;
    logic signed [NW:0]     sm_x, sm_y;
    logic signed [2*NW+1:0] sm_p;

    // output register
    logic                 r_ovld;
    frsm_pkg::t_kind      r_o_kind;
    logic signed [AW-1:0] r_o_num;
    logic [DW-1:0]        r_o_den;
    logic signed [NW-1:0] r_o_min_num;
    logic [IW-1:0]        r_o_min_den;
    frsm_pkg::t_status    r_o_status;
    logic                 r_o_end;
    logic                 out_load;
    logic                 out_total;

    logic                 cap;
    logic                 eng_idle;
    logic signed [NW-1:0] n_sig;
    logic [AW-1:0]        sn_mag;
    logic                 s1, s2;
    logic [MW-1:0]        add_m;
    logic                 add_neg;
    logic                 sum_ovf;

    assign eng_idle = (r_dv_cnt == '0) && !r_gbusy;
    assign cap      = r_sub && eng_idle;
    assign n_sig    = r_nneg ? -$signed(r_nmag) : $signed(r_nmag);
    assign sn_mag   = r_sn[AW-1] ? AW'(-r_sn) : AW'(r_sn);
    assign s1       = r_sn[AW-1];
    assign s2       = r_nneg && (r_nmag != '0);
    assign bm_p     = bm_x * bm_y;
    assign sm_p     = sm_x * sm_y;
    assign sum_ovf  = (r_prod > DEN_MAX) || (r_q > (r_neg ? NEG_MAG : POS_MAX));

    // signed-magnitude combine of the two cross products
    always_comb begin
        if (s1 == s2) begin
            add_m   = r_m1 + r_m2;
            add_neg = s1;
        end else if (r_m1 >= r_m2) begin
            add_m   = r_m1 - r_m2;
            add_neg = s1;
        end else begin
            add_m   = r_m2 - r_m1;
            add_neg = s2;
        end
    end

    // shared multiplier operands
    always_comb begin
        bm_x = sn_mag;
        bm_y = NW'(r_b);
        sm_x = (NW+1)'(n_sig);
        sm_y = (NW+1)'(r_md);
        case (r_state)
            frsm_pkg::ST_MUL_2: begin
                bm_x = AW'(r_a);
                bm_y = r_nmag;
            end
            frsm_pkg::ST_MUL_DEN: begin
                bm_x = AW'(r_a);
                bm_y = NW'(r_dq);
            end
            frsm_pkg::ST_MUL_MB: begin
                sm_x = (NW+1)'(r_mn);
                sm_y = $signed((NW+1)'(r_d));
            end
            default: begin
            end
        endcase
    end

    // next state and engine launches
    always_comb begin
        n_state     = r_state;
        n_sub       = r_sub;
        o_pop       = 1'b0;
        dv_start    = 1'b0;
        dv_dividend = '0;
        dv_count    = CW'(1);
        gc_start    = 1'b0;
        gc_x        = '0;
        gc_y        = '0;
        out_load    = 1'b0;
        out_total   = 1'b0;
        case (r_state)
            frsm_pkg::ST_IDLE: begin
                o_pop = i_valid;
                if (i_valid) begin
                    n_state = i_entry.zero ? frsm_pkg::ST_OUT_ITEM : frsm_pkg::ST_GCD_ITEM;
                end
            end
            frsm_pkg::ST_GCD_ITEM: begin
                gc_x = AW'(r_nmag);
                gc_y = AW'(r_d);
                gc_start = !r_sub;
                n_sub = !r_sub || !eng_idle;
                if (cap) n_state = frsm_pkg::ST_DIV_N;
            end
            frsm_pkg::ST_DIV_N: begin
                dv_dividend = MW'(r_nmag);
                dv_count = CW'(NW);
                dv_start = !r_sub;
                n_sub = !r_sub || !eng_idle;
                if (cap) n_state = frsm_pkg::ST_DIV_D;
            end
            frsm_pkg::ST_DIV_D: begin
                dv_dividend = MW'(r_d);
                dv_count = CW'(IW);
                dv_start = !r_sub;
                n_sub = !r_sub || !eng_idle;
                if (cap) n_state = frsm_pkg::ST_MUL_MA;
            end
            frsm_pkg::ST_MUL_MA: n_state = frsm_pkg::ST_MUL_MB;
            frsm_pkg::ST_MUL_MB: n_state = frsm_pkg::ST_MIN;
            frsm_pkg::ST_MIN:    n_state = frsm_pkg::ST_GCD_DEN;
            frsm_pkg::ST_GCD_DEN: begin
                gc_x = AW'(r_sd);
                gc_y = AW'(r_d);
                gc_start = !r_sub;
                n_sub = !r_sub || !eng_idle;
                if (cap) n_state = frsm_pkg::ST_DIV_A;
            end
            frsm_pkg::ST_DIV_A: begin
                dv_dividend = MW'(r_sd);
                dv_count = CW'(DW);
                dv_start = !r_sub;
                n_sub = !r_sub || !eng_idle;
                if (cap) n_state = frsm_pkg::ST_DIV_B;
            end
            frsm_pkg::ST_DIV_B: begin
                dv_dividend = MW'(r_d);
                dv_count = CW'(IW);
                dv_start = !r_sub;
                n_sub = !r_sub || !eng_idle;
                if (cap) n_state = frsm_pkg::ST_MUL_1;
            end
            frsm_pkg::ST_MUL_1: n_state = frsm_pkg::ST_MUL_2;
            frsm_pkg::ST_MUL_2: n_state = frsm_pkg::ST_ADD;
            frsm_pkg::ST_ADD: begin
                n_state = (add_m == '0) ? frsm_pkg::ST_OUT_ITEM : frsm_pkg::ST_DIV_M;
            end
            frsm_pkg::ST_DIV_M: begin
                dv_dividend = r_m;
                dv_count = CW'(MW);
                dv_start = !r_sub;
                n_sub = !r_sub || !eng_idle;
                if (cap) n_state = frsm_pkg::ST_GCD_REM;
            end
            frsm_pkg::ST_GCD_REM: begin
                gc_x = r_g;
                gc_y = r_rem;
                gc_start = !r_sub;
                n_sub = !r_sub || !eng_idle;
                if (cap) n_state = frsm_pkg::ST_DIV_Q;
            end
            frsm_pkg::ST_DIV_Q: begin
                dv_dividend = r_m;
                dv_count = CW'(MW);
                dv_start = !r_sub;
                n_sub = !r_sub || !eng_idle;
                if (cap) n_state = frsm_pkg::ST_DIV_DQ;
            end
            frsm_pkg::ST_DIV_DQ: begin
                dv_dividend = MW'(r_d);
                dv_count = CW'(IW);
                dv_start = !r_sub;
                n_sub = !r_sub || !eng_idle;
                if (cap) n_state = frsm_pkg::ST_MUL_DEN;
            end
            frsm_pkg::ST_MUL_DEN: n_state = frsm_pkg::ST_CHECK;
            frsm_pkg::ST_CHECK:   n_state = frsm_pkg::ST_OUT_ITEM;
            frsm_pkg::ST_OUT_ITEM: begin
                if (!r_ovld || o_res.ready) begin
                    out_load = 1'b1;
                    n_state  = r_last ? frsm_pkg::ST_OUT_SUM : frsm_pkg::ST_IDLE;
                end
            end
            frsm_pkg::ST_OUT_SUM: begin
                if (!r_ovld || o_res.ready) begin
                    out_load  = 1'b1;
                    out_total = 1'b1;
                    n_state   = frsm_pkg::ST_IDLE;
                end
            end
            default: n_state = frsm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= frsm_pkg::ST_IDLE;
            r_sub   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sub   <= n_sub;
        end
    end

    // restoring divider, one quotient bit a cycle
    assign dv_shift_r = {r_dv_r, r_dv_q[MW-1]};
    assign dv_ge      = dv_shift_r >= {1'b0, r_dv_v};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_cnt <= '0;
        end else if (dv_start) begin
            r_dv_cnt <= dv_count;
        end else if (r_dv_cnt != '0) begin
            r_dv_cnt <= r_dv_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (dv_start) begin
            // left align so the quotient lands in the low bits
            r_dv_q <= dv_dividend << (CW'(MW) - dv_count);
            r_dv_r <= '0;
            r_dv_v <= r_g;
        end else if (r_dv_cnt != '0) begin
            r_dv_q <= {r_dv_q[MW-2:0], dv_ge};
            r_dv_r <= dv_ge ? AW'(dv_shift_r - {1'b0, r_dv_v}) : AW'(dv_shift_r);
        end
    end

    // binary gcd, one subtract or halving a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gbusy <= 1'b0;
        end else if (gc_start) begin
            r_gbusy <= 1'b1;
        end else if (r_gbusy && ((r_gx == '0) || (r_gy == '0))) begin
            r_gbusy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (gc_start) begin
            r_gx <= gc_x;
            r_gy <= gc_y;
            r_gk <= '0;
        end else if (r_gbusy) begin
            if (r_gx == '0) begin
                r_gres <= r_gy << r_gk;
            end else if (r_gy == '0) begin
                r_gres <= r_gx << r_gk;
            end else if (!r_gx[0] && !r_gy[0]) begin
                r_gx <= r_gx >> 1;
                r_gy <= r_gy >> 1;
                r_gk <= r_gk + KW'(1);
            end else if (!r_gx[0]) begin
                r_gx <= r_gx >> 1;
            end else if (!r_gy[0]) begin
                r_gy <= r_gy >> 1;
            end else if (r_gx >= r_gy) begin
                r_gx <= r_gx - r_gy;
            end else begin
                r_gy <= r_gy - r_gx;
            end
        end
    end

    // item and sum datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            frsm_pkg::ST_IDLE: begin
                r_last   <= i_entry.last;
                r_nneg   <= i_entry.neg;
                r_nmag   <= i_entry.mag;
                r_d      <= i_entry.den;
                r_status <= i_entry.zero ? frsm_pkg::STAT_ZERO_DEN : frsm_pkg::STAT_OK;
            end
            frsm_pkg::ST_GCD_ITEM, frsm_pkg::ST_GCD_DEN, frsm_pkg::ST_GCD_REM: begin
                if (cap) r_g <= r_gres;
            end
            frsm_pkg::ST_DIV_N:  if (cap) r_nmag <= r_dv_q[NW-1:0];
            frsm_pkg::ST_DIV_D:  if (cap) r_d    <= r_dv_q[IW-1:0];
            frsm_pkg::ST_MUL_MA: r_pa <= sm_p;
            frsm_pkg::ST_MUL_MB: r_pb <= sm_p;
            frsm_pkg::ST_DIV_A:  if (cap) r_a    <= r_dv_q[DW-1:0];
            frsm_pkg::ST_DIV_B:  if (cap) r_b    <= r_dv_q[IW-1:0];
            frsm_pkg::ST_MUL_1:  r_m1 <= bm_p;
            frsm_pkg::ST_MUL_2:  r_m2 <= bm_p;
            frsm_pkg::ST_ADD: begin
                r_m   <= add_m;
                r_neg <= add_neg;
            end
            frsm_pkg::ST_DIV_M:  if (cap) r_rem <= r_dv_r;
            frsm_pkg::ST_DIV_Q:  if (cap) r_q   <= r_dv_q;
            frsm_pkg::ST_DIV_DQ: if (cap) r_dq  <= r_dv_q[IW-1:0];
            frsm_pkg::ST_MUL_DEN: r_prod <= bm_p;
            frsm_pkg::ST_CHECK: begin
                if (sum_ovf) r_status <= frsm_pkg::STAT_OVERFLOW;
            end
            default: begin
            end
        endcase
    end

    // list state: running sum, running minimum, overflow mark
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sn <= '0;
            r_sd <= DW'(1);
            r_mn <= '0;
            r_md <= NW'(1);
            r_mv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            case (r_state)
                frsm_pkg::ST_MIN: begin
                    // earliest smallest wins on a tie
                    if (!r_mv || (r_pa < r_pb)) begin
                        r_mn <= n_sig;
                        r_md <= NW'(r_d);
                        r_mv <= 1'b1;
                    end
                end
                frsm_pkg::ST_ADD: begin
                    if (add_m == '0) begin
                        r_sn <= '0;
                        r_sd <= DW'(1);
                    end
                end
                frsm_pkg::ST_CHECK: begin
                    if (sum_ovf) begin
                        r_ov <= 1'b1;
                    end else begin
                        r_sd <= r_prod[DW-1:0];
                        r_sn <= r_neg ? -$signed(r_q[AW-1:0]) : $signed(r_q[AW-1:0]);
                    end
                end
                frsm_pkg::ST_OUT_SUM: begin
                    if (out_load) begin
                        r_sn <= '0;
                        r_sd <= DW'(1);
                        r_mn <= '0;
                        r_md <= NW'(1);
                        r_mv <= 1'b0;
                        r_ov <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (out_load) begin
            r_ovld <= 1'b1;
        end else if (o_res.ready) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            if (out_total) begin
                r_o_kind    <= frsm_pkg::KIND_TOTAL;
                r_o_num     <= r_sn;
                r_o_den     <= r_sd;
                r_o_min_num <= r_mn;
                r_o_min_den <= r_md[IW-1:0];
                r_o_status  <= r_ov ? frsm_pkg::STAT_OVERFLOW : frsm_pkg::STAT_OK;
                r_o_end     <= 1'b1;
            end else begin
                r_o_kind    <= frsm_pkg::KIND_ITEM;
                r_o_num     <= AW'(n_sig);
                r_o_den     <= DW'(r_d);
                r_o_min_num <= '0;
                r_o_min_den <= '0;
                r_o_status  <= r_status;
                r_o_end     <= !r_last;
            end
        end
    end

    assign o_res.valid      = r_ovld;
    assign o_res.kind       = r_o_kind;
    assign o_res.num        = r_o_num;
    assign o_res.den        = r_o_den;
    assign o_res.min_num    = r_o_min_num;
    assign o_res.min_den    = r_o_min_den;
    assign o_res.status     = r_o_status;
    assign o_res.end_of_run = r_o_end;

    `FRSM_ASSERT_SAME(a_engine_free, i_clk, i_rst_n, dv_start || gc_start, eng_idle, "engine launched while busy")
    `FRSM_ASSERT_SAME(a_den_nonzero, i_clk, i_rst_n, r_ovld, r_o_den != '0, "zero denominator in result")
    `FRSM_ASSERT_NEXT(a_pop_starts, i_clk, i_rst_n, o_pop, r_state != frsm_pkg::ST_IDLE, "pop left sequencer idle")

endmodule

// File: design/fraction_reduce_sum_min_unit.sv
// top level of the fraction reduce / sum / min unit: front end, queue, sequencer
// depends on frsm_pkg, frsm_in_if, frsm_out_if, frsm_front, frsm_queue, frsm_back
//
// channel  dir  word contents
// i_item   in   numerator, denominator, last
// o_res    out  kind, num, den, min_num, min_den, status, end_of_run
//
// per word: a zero denominator goes straight from the sequencer's idle state to the result
// otherwise seven one-bit-a-cycle divisions of 16 to 49 quotient bits
//   and three binary gcd runs of one subtract or halving a cycle;
//   a sum that cancels to zero skips one gcd and three divisions
// a last word adds a totals word after its item word
// reset: synchronous, active low; sum 0/1, minimum 0/1, no overflow
// stalls: the front register and a two-word queue keep taking input while
//   the sequencer works; a held result word stalls only the sequencer
`timescale 1ns / 1ps

module fraction_reduce_sum_min_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    frsm_in_if.sink    i_item,
    frsm_out_if.source o_res
);

    logic            push;
    logic            full;
    logic            pop;
    logic            head_valid;
    frsm_pkg::t_item front_entry;
    frsm_pkg::t_item head_entry;

    // sign correction and zero-denominator classification
    frsm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_full  (full),
        .o_push  (push),
        .o_entry (front_entry)
    );

    // decouples intake from the long per-word sequence
    frsm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_head  (head_entry)
    );

    // gcd reduction, minimum tracking, reduced running sum, result register
    frsm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (head_valid),
        .i_entry (head_entry),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule
